// File: rtl/ggp_pkg.sv
// ----------------------------------------------------------------------------
// ggp_pkg
// Shared types and constants of the geometric grid partitioner.
// ----------------------------------------------------------------------------
package ggp_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_COORD_BITS = 32;
  localparam int DEF_MAX_GROUPS = 16;

  localparam int ROW_W    = 54;
  localparam int COEF_W   = 18;
  localparam int FIELD_W  = 32;
  localparam int WGT_W    = 16;
  localparam int IDX_W    = 10;
  localparam int LBL_W    = 12;
  localparam int GCFG_W   = 5;
  localparam int CFG_IW   = 3;
  localparam int IN_DW    = 128;
  localparam int OUT_DW   = 24;

  localparam logic [ROW_W-1:0] ROW_X_RST = 54'd65536;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 54'd65536 << 18;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 54'd65536 << 36;

  typedef enum logic [CFG_IW-1:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_GRP_X  = 3'd3,
    REG_GRP_Y  = 3'd4,
    REG_GRP_Z  = 3'd5,
    REG_USE_W  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_NXT,
    PH_K_ORD,
    PH_K_CRD,
    PH_K_MUL,
    PH_K_SUM,
    PH_S_INI,
    PH_S_LD,
    PH_S_LD2,
    PH_S_RD,
    PH_S_CMP,
    PH_S_PUT,
    PH_D_INIT,
    PH_D_STEP,
    PH_A_ORD,
    PH_A_LAB,
    PH_A_CAP,
    PH_A_ADV,
    PH_A_WR,
    PH_FIN
  } phase_t;

  typedef struct packed {
    phase_t op;
    axis_t  axis;
    logic   accept;
  } ggp_cmd_t;

  typedef struct packed {
    logic rd_pend;
    logic out_valid;
    logic i_end;
    logic n_small;
    logic j_zero;
    logic key_gt;
    logic div_ge;
    logic adv;
    logic ind_end;
  } ggp_stat_t;

endpackage

// File: rtl/ggp_ram.sv
// ----------------------------------------------------------------------------
// ggp_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ggp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ggp_ctrl.sv
// ----------------------------------------------------------------------------
// ggp_ctrl
// Sequencer: input handshake, key build, insertion sort and group assignment.
// ----------------------------------------------------------------------------
module ggp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  input  logic               in_tlast,
  input  logic               out_tready,
  input  ggp_pkg::ggp_stat_t stat,
  output ggp_pkg::ggp_cmd_t  cmd
);
  import ggp_pkg::*;

  phase_t state_r, state_nxt;
  axis_t  axis_r, axis_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    in_tready  = (state_r == PH_IDLE) && !stat.rd_pend && (!stat.out_valid || out_tready);
    accept     = in_tvalid && in_tready;
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    cmd.op     = state_r;
    cmd.axis   = axis_r;
    cmd.accept = accept;
    unique case (state_r)
      PH_IDLE: begin
        if (accept && !in_tuser && in_tlast) begin
          state_nxt = PH_NXT;
          axis_nxt  = AXIS_X;
        end
      end
      PH_NXT:   state_nxt = PH_K_ORD;
      PH_K_ORD: state_nxt = PH_K_CRD;
      PH_K_CRD: state_nxt = PH_K_MUL;
      PH_K_MUL: state_nxt = PH_K_SUM;
      PH_K_SUM: state_nxt = stat.i_end ? PH_S_INI : PH_K_ORD;
      PH_S_INI: state_nxt = stat.n_small ? PH_D_INIT : PH_S_LD;
      PH_S_LD:  state_nxt = PH_S_LD2;
      PH_S_LD2: state_nxt = PH_S_RD;
      PH_S_RD:  state_nxt = stat.j_zero ? PH_S_PUT : PH_S_CMP;
      PH_S_CMP: state_nxt = stat.key_gt ? PH_S_RD : PH_S_PUT;
      PH_S_PUT: state_nxt = stat.i_end ? PH_D_INIT : PH_S_LD;
      PH_D_INIT: state_nxt = PH_D_STEP;
      PH_D_STEP: begin
        if (!stat.div_ge) begin
          state_nxt = PH_A_ORD;
        end
      end
      PH_A_ORD: state_nxt = PH_A_LAB;
      PH_A_LAB: state_nxt = PH_A_CAP;
      PH_A_CAP: state_nxt = PH_A_ADV;
      PH_A_ADV: begin
        if (!stat.adv) begin
          state_nxt = PH_A_WR;
        end
      end
      PH_A_WR: begin
        if (!stat.ind_end) begin
          state_nxt = PH_A_ORD;
        end else if (axis_r == AXIS_Z) begin
          state_nxt = PH_FIN;
        end else begin
          state_nxt = PH_NXT;
          axis_nxt  = (axis_r == AXIS_X) ? AXIS_Y : AXIS_Z;
        end
      end
      PH_FIN:  state_nxt = PH_IDLE;
      default: state_nxt = PH_IDLE;
    endcase
  end

endmodule

// File: rtl/ggp_datapath.sv
// ----------------------------------------------------------------------------
// ggp_datapath
// Point stores, rotation keys, sort and group counters, label store, output.
// ----------------------------------------------------------------------------
module ggp_datapath #(
  parameter int MAX_POINTS = ggp_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = ggp_pkg::DEF_COORD_BITS,
  parameter int MAX_GROUPS = ggp_pkg::DEF_MAX_GROUPS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ggp_pkg::ggp_cmd_t            cmd,
  output ggp_pkg::ggp_stat_t           stat,
  input  logic                         cfg_we,
  input  logic [ggp_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ggp_pkg::ROW_W-1:0]    cfg_wdata,
  input  logic [ggp_pkg::IN_DW-1:0]    in_tdata,
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ggp_pkg::OUT_DW-1:0]   out_tdata,
  output logic                         out_tuser
);
  import ggp_pkg::*;

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int TW  = WGT_W + IW;
  localparam int GW  = $clog2(MAX_GROUPS + 1);
  localparam int SW  = TW + GW;
  localparam int PW  = COORD_BITS + COEF_W;
  localparam int KW  = (COORD_BITS + 20 > 64) ? 64 : COORD_BITS + 20;

  logic [ROW_W-1:0]  rowx_r, rowy_r, rowz_r;
  logic [GCFG_W-1:0] grpx_r, grpy_r, grpz_r;
  logic              usew_r;

  logic [CW-1:0] count_r;
  logic [TW-1:0] total_r;
  logic          done_r;

  logic [CW-1:0] i_r, j_r, ind_r, rem_r, jump_r, gk_r;
  logic [IW-1:0] t_r, p_r;
  logic [KW-1:0] k_r;
  logic [GW-1:0] gj_r;
  logic [SW-1:0] sumg_r, thr_r;
  logic [LBL_W-1:0] labc_r, mult_r;
  logic [WGT_W-1:0] w_r;
  logic signed [PW-1:0] prod0_r, prod1_r, prod2_r;

  logic          rd_pend_r, rd_ok_r, out_valid_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [OUT_DW-1:0] out_data_r;
  logic          out_user_r;

  // ram ports
  logic                  ld_we;
  logic [IW-1:0]         ld_addr, crd_raddr;
  logic [COORD_BITS-1:0] x_rdata, y_rdata, z_rdata;
  logic [WGT_W-1:0]      w_rdata;
  logic                  ord_we, kp_we, lab_we;
  logic [IW-1:0]         ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic [IW-1:0]         kp_waddr, kp_raddr, lab_waddr, lab_raddr;
  logic [KW-1:0]         kp_wdata, kp_rdata;
  logic [LBL_W-1:0]      lab_wdata, lab_rdata;

  // input fields
  logic [FIELD_W-1:0] f_x, f_y, f_z;
  logic [WGT_W-1:0]   f_w;
  logic [IDX_W-1:0]   f_idx;
  logic [CW-1:0]      base;
  logic               full, is_load, is_read;

  logic [GW-1:0] gx, gy, gz, gcur;
  logic signed [COEF_W-1:0] c0, c1, c2;
  logic [ROW_W-1:0] row;
  logic signed [KW-1:0] key_sum;
  logic [CW-1:0] len;
  logic [LBL_W-1:0] new_lab;

  function automatic logic [GW-1:0] clamp_g(input logic [GCFG_W-1:0] g);
    logic [GW-1:0] r;
    if (g == '0) begin
      r = GW'(1);
    end else if (32'(g) > 32'(MAX_GROUPS)) begin
      r = GW'(MAX_GROUPS);
    end else begin
      r = GW'(g);
    end
    return r;
  endfunction

  assign f_x   = in_tdata[31:0];
  assign f_y   = in_tdata[63:32];
  assign f_z   = in_tdata[95:64];
  assign f_w   = in_tdata[111:96];
  assign f_idx = in_tdata[121:112];

  assign is_load = cmd.accept && !in_tuser;
  assign is_read = cmd.accept && in_tuser;
  assign base    = done_r ? '0 : count_r;
  assign full    = (base == CW'(MAX_POINTS));
  assign ld_we   = is_load && !full;
  assign ld_addr = base[IW-1:0];

  assign gx = clamp_g(grpx_r);
  assign gy = clamp_g(grpy_r);
  assign gz = clamp_g(grpz_r);

  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  begin gcur = gx; row = rowx_r; end
      AXIS_Y:  begin gcur = gy; row = rowy_r; end
      AXIS_Z:  begin gcur = gz; row = rowz_r; end
      default: begin gcur = gx; row = rowx_r; end
    endcase
  end

  assign c0 = row[17:0];
  assign c1 = row[35:18];
  assign c2 = row[53:36];
  assign key_sum = KW'(prod0_r) + KW'(prod1_r) + KW'(prod2_r);
  assign len = jump_r + ((32'(gj_r) < 32'(rem_r)) ? CW'(1) : CW'(0));
  assign new_lab = (cmd.axis == AXIS_X) ? LBL_W'(gj_r)
                                        : labc_r + LBL_W'(mult_r * LBL_W'(gj_r));

  always_comb begin
    stat.rd_pend   = rd_pend_r;
    stat.out_valid = out_valid_r;
    stat.i_end     = (i_r + CW'(1) == count_r);
    stat.n_small   = (count_r <= CW'(1));
    stat.j_zero    = (j_r == '0);
    stat.key_gt    = $signed(kp_rdata) > $signed(k_r);
    stat.div_ge    = (32'(rem_r) >= 32'(gcur));
    stat.adv       = usew_r && (32'(gj_r) + 1 < 32'(gcur)) && !(sumg_r < thr_r);
    stat.ind_end   = (ind_r + CW'(1) == count_r);
  end

  always_comb begin
    crd_raddr = '0;
    ord_raddr = '0;
    kp_raddr  = '0;
    lab_raddr = '0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    kp_we     = 1'b0;
    kp_waddr  = '0;
    kp_wdata  = '0;
    lab_we    = 1'b0;
    lab_waddr = '0;
    lab_wdata = '0;
    unique case (cmd.op)
      PH_IDLE:  lab_raddr = IW'(f_idx);
      PH_K_ORD: ord_raddr = i_r[IW-1:0];
      PH_K_CRD: crd_raddr = (cmd.axis == AXIS_X) ? i_r[IW-1:0] : ord_rdata;
      PH_K_SUM: begin
        kp_we    = 1'b1;
        kp_waddr = i_r[IW-1:0];
        kp_wdata = key_sum;
        if (cmd.axis == AXIS_X) begin
          ord_we    = 1'b1;
          ord_waddr = i_r[IW-1:0];
          ord_wdata = i_r[IW-1:0];
        end
      end
      PH_S_LD: begin
        ord_raddr = i_r[IW-1:0];
        kp_raddr  = i_r[IW-1:0];
      end
      PH_S_RD: begin
        ord_raddr = IW'(j_r - CW'(1));
        kp_raddr  = IW'(j_r - CW'(1));
      end
      PH_S_CMP: begin
        if (stat.key_gt) begin
          ord_we    = 1'b1;
          ord_waddr = j_r[IW-1:0];
          ord_wdata = ord_rdata;
          kp_we     = 1'b1;
          kp_waddr  = j_r[IW-1:0];
          kp_wdata  = kp_rdata;
        end
      end
      PH_S_PUT: begin
        ord_we    = 1'b1;
        ord_waddr = j_r[IW-1:0];
        ord_wdata = t_r;
        kp_we     = 1'b1;
        kp_waddr  = j_r[IW-1:0];
        kp_wdata  = k_r;
      end
      PH_A_ORD: ord_raddr = ind_r[IW-1:0];
      PH_A_LAB: begin
        lab_raddr = ord_rdata;
        crd_raddr = ord_rdata;
      end
      PH_A_WR: begin
        lab_we    = 1'b1;
        lab_waddr = p_r;
        lab_wdata = new_lab;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowx_r      <= ROW_X_RST;
      rowy_r      <= ROW_Y_RST;
      rowz_r      <= ROW_Z_RST;
      grpx_r      <= GCFG_W'(1);
      grpy_r      <= GCFG_W'(1);
      grpz_r      <= GCFG_W'(1);
      usew_r      <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      done_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_X: rowx_r <= cfg_wdata;
          REG_ROW_Y: rowy_r <= cfg_wdata;
          REG_ROW_Z: rowz_r <= cfg_wdata;
          REG_GRP_X: grpx_r <= cfg_wdata[GCFG_W-1:0];
          REG_GRP_Y: grpy_r <= cfg_wdata[GCFG_W-1:0];
          REG_GRP_Z: grpz_r <= cfg_wdata[GCFG_W-1:0];
          REG_USE_W: usew_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (is_load) begin
        done_r <= 1'b0;
        if (!full) begin
          count_r <= base + CW'(1);
          total_r <= (done_r ? '0 : total_r) + TW'(f_w);
        end else begin
          count_r <= base;
          total_r <= done_r ? '0 : total_r;
        end
      end
      if (cmd.op == PH_FIN) begin
        done_r <= 1'b1;
      end
      rd_pend_r <= is_read;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      rd_idx_r <= f_idx;
      rd_ok_r  <= !done_r ? 1'b0 : (32'(f_idx) < 32'(count_r));
    end
    if (rd_pend_r) begin
      out_data_r <= {2'b00, (rd_ok_r ? lab_rdata : LBL_W'(0)), rd_idx_r};
      out_user_r <= rd_ok_r;
    end
    unique case (cmd.op)
      PH_NXT:   i_r <= '0;
      PH_K_MUL: begin
        prod0_r <= c0 * $signed(x_rdata);
        prod1_r <= c1 * $signed(y_rdata);
        prod2_r <= c2 * $signed(z_rdata);
      end
      PH_K_SUM: i_r <= i_r + CW'(1);
      PH_S_INI: i_r <= CW'(1);
      PH_S_LD2: begin
        t_r <= ord_rdata;
        k_r <= kp_rdata;
        j_r <= i_r;
      end
      PH_S_CMP: begin
        if (stat.key_gt) begin
          j_r <= j_r - CW'(1);
        end
      end
      PH_S_PUT: i_r <= i_r + CW'(1);
      PH_D_INIT: begin
        rem_r  <= count_r;
        jump_r <= '0;
        gj_r   <= '0;
        gk_r   <= '0;
        ind_r  <= '0;
        sumg_r <= '0;
        thr_r  <= SW'(total_r);
        mult_r <= (cmd.axis == AXIS_Y) ? LBL_W'(gx) : LBL_W'(gx) * LBL_W'(gy);
      end
      PH_D_STEP: begin
        if (stat.div_ge) begin
          rem_r  <= rem_r - CW'(gcur);
          jump_r <= jump_r + CW'(1);
        end
      end
      PH_A_LAB: p_r <= ord_rdata;
      PH_A_CAP: begin
        labc_r <= lab_rdata;
        w_r    <= w_rdata;
      end
      PH_A_ADV: begin
        if (stat.adv) begin
          gj_r  <= gj_r + GW'(1);
          thr_r <= thr_r + SW'(total_r);
        end
      end
      PH_A_WR: begin
        ind_r  <= ind_r + CW'(1);
        sumg_r <= sumg_r + SW'(w_r) * SW'(gcur);
        if (!usew_r) begin
          if (gk_r + CW'(1) == len) begin
            gj_r <= gj_r + GW'(1);
            gk_r <= '0;
          end else begin
            gk_r <= gk_r + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  ggp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(COORD_BITS'(f_x)),
    .raddr(crd_raddr), .rdata(x_rdata)
  );

  ggp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(COORD_BITS'(f_y)),
    .raddr(crd_raddr), .rdata(y_rdata)
  );

  ggp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_z (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(COORD_BITS'(f_z)),
    .raddr(crd_raddr), .rdata(z_rdata)
  );

  ggp_ram #(.WIDTH(WGT_W), .DEPTH(MAX_POINTS)) u_ram_w (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(f_w),
    .raddr(crd_raddr), .rdata(w_rdata)
  );

  ggp_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_ram_ord (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  ggp_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_ram_key (
    .clk(clk), .we(kp_we), .waddr(kp_waddr), .wdata(kp_wdata),
    .raddr(kp_raddr), .rdata(kp_rdata)
  );

  ggp_ram #(.WIDTH(LBL_W), .DEPTH(MAX_POINTS)) u_ram_lab (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata)
  );

endmodule

// File: rtl/geometric_grid_partitioner_unit.sv
// ----------------------------------------------------------------------------
// geometric_grid_partitioner_unit
// Weighted point loader with rotated-axis grid decomposition and label reads.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) yields no result; a read beat (tuser 1) returns its
// label through the read-pending and output registers, and the next beat is
// not taken before the cycle that result is taken. A load with tlast starts the
// decomposition, which holds in_tready low through key build, insertion sort,
// even-split division and assignment (plus group skips) per axis, all three
// axes in turn; the insertion sort works through the single read port of the
// order and key memories.
module geometric_grid_partitioner_unit #(
  parameter int MAX_POINTS = ggp_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = ggp_pkg::DEF_COORD_BITS,
  parameter int MAX_GROUPS = ggp_pkg::DEF_MAX_GROUPS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ggp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ggp_pkg::ROW_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // point_x, point_y, point_z, point_weight, read_index
  input  logic [ggp_pkg::IN_DW-1:0]  in_tdata,
  // cmd
  input  logic                       in_tuser,
  // last_point
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // point_number, processor_label
  output logic [ggp_pkg::OUT_DW-1:0] out_tdata,
  // label_valid
  output logic                       out_tuser
);
  import ggp_pkg::*;

  ggp_cmd_t  cmd;
  ggp_stat_t stat;

  ggp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ggp_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS),
    .MAX_GROUPS(MAX_GROUPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Geometric grid partitioner bench
// Streams point sets and label reads into the partitioner through a queued
// driver, rebuilds every decomposition in a behavioral predictor (rotation,
// stable per-axis sorts, even or weighted split) and compares each label beat
// with the oldest predicted label. Configuration changes between point sets.
// ----------------------------------------------------------------------------
module tb;
  import ggp_pkg::*;

  localparam int NPTS      = DEF_MAX_POINTS;
  localparam int NGRP      = DEF_MAX_GROUPS;
  localparam int CYCLE_CAP = 4000000;

  typedef struct {
    bit                 rd;
    logic signed [31:0] x, y, z;
    logic [15:0]        w;
    bit                 last;
    logic [9:0]         idx;
  } beat_t;

  typedef struct {
    logic [9:0]  num;
    logic [11:0] label;
    logic        valid;
  } label_t;

  logic                clk, rst_n;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [ROW_W-1:0]    cfg_wdata;
  logic                in_tvalid, in_tready, in_tuser, in_tlast;
  logic [IN_DW-1:0]    in_tdata;
  logic                out_tvalid, out_tready, out_tuser;
  logic [OUT_DW-1:0]   out_tdata;

  beat_t  pending_beats[$];
  label_t label_fifo[$];
  int     errors = 0;
  int     send_idle = 37, recv_idle = 77;
  int     items = 0;
  longint cycles = 0;

  // predictor state
  logic [ROW_W-1:0]   row_x, row_y, row_z;
  logic [4:0]         grp_x, grp_y, grp_z;
  bit                 by_weight;
  logic signed [31:0] sx[NPTS], sy[NPTS], sz[NPTS];
  logic [15:0]        sw[NPTS];
  int unsigned        lab[NPTS];
  int unsigned        order[NPTS];
  longint signed      akey[NPTS];
  int unsigned        npts;
  longint unsigned    wsum_all;
  bit                 decomposed;

  geometric_grid_partitioner_unit DUT (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint signed coef(logic [ROW_W-1:0] row, int sel);
    logic [17:0] c;
    c = row[sel*COEF_W +: COEF_W];
    return longint'(signed'(c));
  endfunction

  function automatic int unsigned clamp_grp(logic [4:0] g);
    if (g == 0) return 1;
    if (g > NGRP) return NGRP;
    return g;
  endfunction

  function automatic void sort_axis(logic [ROW_W-1:0] row);
    longint signed c0, c1, c2, k;
    int unsigned t, j;
    c0 = coef(row, 0);
    c1 = coef(row, 1);
    c2 = coef(row, 2);
    for (int i = 0; i < npts; i++)
      akey[i] = c0 * longint'(sx[i]) + c1 * longint'(sy[i]) + c2 * longint'(sz[i]);
    for (int i = 1; i < npts; i++) begin
      t = order[i];
      k = akey[t];
      j = i;
      while (j > 0 && akey[order[j-1]] > k) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = t;
    end
  endfunction

  function automatic void split_axis(int unsigned g, int unsigned mult);
    int unsigned pos, len, jump, extra;
    longint unsigned acc;
    pos = 0;
    acc = 0;
    if (by_weight) begin
      for (int unsigned j = 0; j + 1 < g; j++)
        while (pos < npts && acc * g < wsum_all * longint'(j + 1)) begin
          acc += sw[order[pos]];
          lab[order[pos]] += mult * j;
          pos++;
        end
    end else begin
      jump  = npts / g;
      extra = npts - jump * g;
      for (int unsigned j = 0; j < g && pos < npts; j++) begin
        len = jump + ((j < extra) ? 1 : 0);
        for (int unsigned k = 0; k < len && pos < npts; k++) begin
          lab[order[pos]] += mult * j;
          pos++;
        end
      end
    end
    for (; pos < npts; pos++) lab[order[pos]] += mult * (g - 1);
  endfunction

  function automatic void partition_points();
    int unsigned gx, gy, gz;
    gx = clamp_grp(grp_x);
    gy = clamp_grp(grp_y);
    gz = clamp_grp(grp_z);
    for (int i = 0; i < npts; i++) begin
      order[i] = i;
      lab[i]   = 0;
    end
    sort_axis(row_x);
    split_axis(gx, 1);
    sort_axis(row_y);
    split_axis(gy, gx);
    sort_axis(row_z);
    split_axis(gz, gx * gy);
    decomposed = 1'b1;
  endfunction

  function automatic void predict_beat(beat_t b);
    label_t e;
    if (!b.rd) begin
      if (decomposed) begin
        decomposed = 1'b0;
        npts       = 0;
        wsum_all   = 0;
      end
      if (npts < NPTS) begin
        sx[npts] = b.x;
        sy[npts] = b.y;
        sz[npts] = b.z;
        sw[npts] = b.w;
        wsum_all += b.w;
        npts++;
      end
      if (b.last) partition_points();
    end else begin
      e.num   = b.idx;
      e.valid = decomposed && (b.idx < npts);
      e.label = e.valid ? lab[b.idx][11:0] : 12'd0;
      label_fifo.push_back(e);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= 1'b0;
      in_tlast   <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          beat_t b;
          b = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= b.rd;
          in_tlast  <= b.last;
          in_tdata  <= {6'd0, b.idx, b.w, b.z, b.y, b.x};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        beat_t b;
        b.rd   = in_tuser;
        b.last = in_tlast;
        b.x    = in_tdata[31:0];
        b.y    = in_tdata[63:32];
        b.z    = in_tdata[95:64];
        b.w    = in_tdata[111:96];
        b.idx  = in_tdata[121:112];
        predict_beat(b);
      end
      if (out_tvalid && out_tready) begin
        if (label_fifo.size() == 0) begin
          $error("unexpected label beat %h", out_tdata);
          errors++;
        end else begin
          label_t e;
          e = label_fifo.pop_front();
          if (out_tdata[9:0] !== e.num) begin
            $error("point_number expected %0d actual %0d", e.num, out_tdata[9:0]);
            errors++;
          end
          if (out_tdata[21:10] !== e.label) begin
            $error("processor_label expected %0d actual %0d", e.label, out_tdata[21:10]);
            errors++;
          end
          if (out_tuser !== e.valid) begin
            $error("label_valid expected %0d actual %0d", e.valid, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t r, logic [ROW_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (r)
      REG_ROW_X: row_x = v;
      REG_ROW_Y: row_y = v;
      REG_ROW_Z: row_z = v;
      REG_GRP_X: grp_x = v[4:0];
      REG_GRP_Y: grp_y = v[4:0];
      REG_GRP_Z: grp_z = v[4:0];
      default:   by_weight = v[0];
    endcase
  endtask

  task automatic push_load(logic signed [31:0] x, y, z, logic [15:0] w, bit last);
    beat_t b;
    b = '{rd: 1'b0, x: x, y: y, z: z, w: w, last: last, idx: 10'($urandom)};
    pending_beats.push_back(b);
    items++;
  endtask

  task automatic push_read(logic [9:0] idx);
    beat_t b;
    b = '{rd: 1'b1, x: $urandom, y: $urandom, z: $urandom, w: 16'($urandom),
          last: $urandom_range(1), idx: idx};
    pending_beats.push_back(b);
    items++;
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_tvalid && label_fifo.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int unsigned pool);
    case ($urandom_range(5))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return $urandom_range(pool) - pool / 2;
      default: return $urandom;
    endcase
  endfunction

  // one point set of n loads with random content (or zero coordinates), occasional reads between loads, then reads
  task automatic point_set(int n, bit zero_coords);
    int unsigned pool, wmode;
    int nrd;
    pool  = $urandom_range(1) ? 3 : 1000;
    wmode = $urandom_range(3);
    nrd   = (n > 60) ? 40 : n + 2;
    for (int i = 0; i < n; i++) begin
      logic [15:0] w;
      w = (wmode == 0) ? 16'd0 : (wmode == 1) ? 16'hFFFF : 16'($urandom);
      if (zero_coords) push_load(0, 0, 0, w, i == n - 1);
      else push_load(rand_coord(pool), rand_coord(pool), rand_coord(pool), w, i == n - 1);
      if (i < n - 1 && $urandom_range(15) == 0) push_read(10'($urandom_range(n)));
    end
    for (int i = 0; i < nrd; i++)
      push_read(($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(n)));
  endtask

  task automatic random_config();
    logic [4:0] g[3];
    for (int a = 0; a < 3; a++)
      case ($urandom_range(5))
        0:       g[a] = 5'd0;
        1:       g[a] = 5'd31;
        2:       g[a] = 5'd16;
        default: g[a] = 5'($urandom_range(1, 6));
      endcase
    write_reg(REG_GRP_X, ROW_W'(g[0]));
    write_reg(REG_GRP_Y, ROW_W'(g[1]));
    write_reg(REG_GRP_Z, ROW_W'(g[2]));
    write_reg(REG_USE_W, ROW_W'($urandom_range(1)));
    write_reg(REG_ROW_X, ($urandom_range(2) == 0) ? ROW_X_RST : ROW_W'({$urandom, $urandom}));
    write_reg(REG_ROW_Y, ($urandom_range(2) == 0) ? ROW_Y_RST : ROW_W'({$urandom, $urandom}));
    write_reg(REG_ROW_Z, ($urandom_range(2) == 0) ? ROW_Z_RST : ROW_W'({$urandom, $urandom}));
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    out_tready = 1'b0;
    row_x = ROW_X_RST;
    row_y = ROW_Y_RST;
    row_z = ROW_Z_RST;
    grp_x = 1;
    grp_y = 1;
    grp_z = 1;
    by_weight  = 0;
    npts       = 0;
    wsum_all   = 0;
    decomposed = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reads before any decomposition, extreme points, single-point set
    push_read(10'd0);
    push_read(10'h3FF);
    push_load(32'sh7FFFFFFF, 32'sh80000000, 0, 16'hFFFF, 1'b0);
    push_load(32'sh80000000, 32'sh7FFFFFFF, -1, 16'h0000, 1'b0);
    push_load(0, 0, 32'sh7FFFFFFF, 16'h0100, 1'b0);
    push_load(5, 5, 5, 16'h0001, 1'b1);
    for (int i = 0; i < 5; i++) push_read(10'(i));
    push_load(1, 2, 3, 16'h8000, 1'b1);
    push_read(10'd0);
    push_read(10'd1);
    drain();

    // group counts over the limit, at the limit and zero, extreme coefficients, weighted split
    write_reg(REG_GRP_X, ROW_W'(5'd31));
    write_reg(REG_GRP_Y, ROW_W'(5'd16));
    write_reg(REG_GRP_Z, ROW_W'(5'd0));
    write_reg(REG_USE_W, ROW_W'(1));
    write_reg(REG_ROW_X, {ROW_W{1'b1}});
    write_reg(REG_ROW_Y, '0);
    write_reg(REG_ROW_Z, {18'h20000, 18'h1FFFF, 18'h20000});
    point_set(20, 1'b0);
    drain();

    // overfull set: tied keys keep the sort short
    write_reg(REG_USE_W, ROW_W'(0));
    point_set(NPTS + 1, 1'b1);
    drain();

    while (items < 1450) begin
      if (items > 1370) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (items > 1290) begin
        send_idle = 77;
        recv_idle = 37;
      end
      random_config();
      point_set(($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 24),
                1'b0);
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && label_fifo.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (label_fifo.size() != 0) $error("%0d label beats never arrived", label_fifo.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: geometric_grid_partitioner_unit.f
rtl/ggp_pkg.sv
rtl/ggp_ram.sv
rtl/ggp_ctrl.sv
rtl/ggp_datapath.sv
rtl/geometric_grid_partitioner_unit.sv
bench/tb.sv
